[rtl/hmcg_pkg.sv]
// ----------------------------------------------------------------------------
// hmcg_pkg: shared definitions for the height map gradient core
// Field widths, register codes, input modes and the sequencer state type.
// ----------------------------------------------------------------------------
package hmcg_pkg;

  // Default sizes of the height store and of one stored sample.
  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int HEIGHT_BITS_DEF = 16;

  // Fixed field widths of the ports.
  localparam int CFG_W      = 9;
  localparam int POS_W      = 8;
  localparam int IN_HEIGHT_W = 16;
  localparam int GRAD_W     = 17;
  localparam int GRAD_LIMIT = 65535;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Reset values of the size registers.
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 9'd256;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 9'd256;

  // Register index, taken from paddr[2].
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Input item modes.
  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Query sequencer. Each busy state names the neighbour read it issues;
  // S_GY issues no read and finishes the vertical gradient.
  typedef enum logic [2:0] {
    S_IDLE,
    S_XM,
    S_YP,
    S_YM,
    S_GY
  } seq_state_t;

endpackage

[rtl/height_map_central_gradient_core.sv]
// ----------------------------------------------------------------------------
// height_map_central_gradient_core: height map with wraparound gradients
// Stores height samples and answers central-difference gradient queries.
// ----------------------------------------------------------------------------
// A store beat (mode 0) writes one sample into the height memory in the cycle
// it is accepted and produces no result; the block is ready again in the next
// cycle. A query beat (mode 1) reads the four wraparound neighbours of its
// texel one after another through the single port of the height memory: the
// first read is issued in the accept cycle and the others in S_XM, S_YP and
// S_YM, and each read lands in a registered read port. One shared
// saturating subtractor forms right minus left and then below minus above.
// A query keeps in_stall high while the sequencer steps through S_XM, S_YP,
// S_YM and S_GY, so a new beat is only accepted once the query is through,
// and its result beat is loaded into the output register from S_GY. If that
// register still holds an untaken result, the query waits in its last step
// until the register frees. The output register lets a new store or query be
// accepted while a finished result waits to be taken. Gradients carry one
// implied fractional bit, so the raw difference stands for half of it.
// Queries outside the configured image return zeros, stores there are
// dropped. The height memory has no reset and no clearing pass: an entry must
// be written before a query touches it. Size register values of zero act as
// one, and values above the memory size act as that size.
// ----------------------------------------------------------------------------
module height_map_central_gradient_core #(
  parameter int MAX_WIDTH   = hmcg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = hmcg_pkg::MAX_HEIGHT_DEF,
  parameter int HEIGHT_BITS = hmcg_pkg::HEIGHT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [hmcg_pkg::POS_W-1:0]        in_pos_x,
  input  logic [hmcg_pkg::POS_W-1:0]        in_pos_y,
  input  logic [hmcg_pkg::IN_HEIGHT_W-1:0]  in_height_value,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hmcg_pkg::GRAD_W-1:0] out_grad_x,
  output logic signed [hmcg_pkg::GRAD_W-1:0] out_grad_y,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hmcg_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [hmcg_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [hmcg_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  import hmcg_pkg::*;

  // The memory is addressed as {row, column}; each field is as wide as the
  // largest image in that direction needs.
  localparam int XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW    = XW + YW;
  localparam int DEPTH = 2 ** AW;
  // Width of the difference once extended far enough to test the limit.
  localparam int EW    = (HEIGHT_BITS + 1 > GRAD_W + 1) ? HEIGHT_BITS + 1 : GRAD_W + 1;

  // --------------------------------------------------------------------------
  // Configuration registers. pready is always high, so a write lands at the
  // access phase edge. The register index is paddr[2].
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] width_cfg_r;
  logic [CFG_W-1:0] height_cfg_r;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= WIDTH_RESET;
      height_cfg_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_WIDTH) begin
        width_cfg_r <= pwdata[CFG_W-1:0];
      end else begin
        height_cfg_r <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_HEIGHT) begin
      prdata = APB_DATA_W'(height_cfg_r);
    end else begin
      prdata = APB_DATA_W'(width_cfg_r);
    end
  end

  // Effective image size: zero reads as one, anything above the memory size
  // is clamped to it. The clamped value is below 512 whenever it is taken.
  logic [CFG_W-1:0] w_eff;
  logic [CFG_W-1:0] h_eff;

  always_comb begin
    if (width_cfg_r == '0) begin
      w_eff = CFG_W'(1);
    end else if (int'(width_cfg_r) > MAX_WIDTH) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_cfg_r;
    end
    if (height_cfg_r == '0) begin
      h_eff = CFG_W'(1);
    end else if (int'(height_cfg_r) > MAX_HEIGHT) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_cfg_r;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and data registers.
  // --------------------------------------------------------------------------
  seq_state_t                 state_r, state_nxt;
  logic [POS_W-1:0]           x_r, y_r;
  logic                       inside_r;
  logic [HEIGHT_BITS-1:0]     a_r;
  logic signed [GRAD_W-1:0]   gx_r;
  logic                       out_valid_r;
  logic signed [GRAD_W-1:0]   out_grad_x_r, out_grad_y_r;

  logic                       in_accept;
  logic                       in_inside;
  logic                       slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_inside = ({1'b0, in_pos_x} < w_eff) && ({1'b0, in_pos_y} < h_eff);
  assign slot_free = !out_valid_r || !out_stall;

  // Neighbour coordinates of the current texel, taken from the input in the
  // accept cycle and from the held position afterwards.
  logic [POS_W-1:0] cur_x, cur_y;
  logic [CFG_W-1:0] cx, cy, xm, xp, ym, yp;

  always_comb begin
    if (state_r == S_IDLE) begin
      cur_x = in_pos_x;
      cur_y = in_pos_y;
    end else begin
      cur_x = x_r;
      cur_y = y_r;
    end
    cx = CFG_W'(cur_x);
    cy = CFG_W'(cur_y);
    xm = (cx == '0) ? w_eff - CFG_W'(1) : cx - CFG_W'(1);
    xp = (cx + CFG_W'(1) == w_eff) ? '0 : cx + CFG_W'(1);
    ym = (cy == '0) ? h_eff - CFG_W'(1) : cy - CFG_W'(1);
    yp = (cy + CFG_W'(1) == h_eff) ? '0 : cy + CFG_W'(1);
  end

  // --------------------------------------------------------------------------
  // Height memory: one port, written on a store beat, read once in every query
  // step before S_GY, read data registered.
  // --------------------------------------------------------------------------
  logic [HEIGHT_BITS-1:0] mem [DEPTH];
  logic [HEIGHT_BITS-1:0] rdata_r;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= HEIGHT_BITS'(in_height_value);
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Shared saturating subtractor: held operand minus the word just read.
  // --------------------------------------------------------------------------
  logic signed [HEIGHT_BITS:0] sub_d;
  logic signed [EW-1:0]        sub_e;
  logic signed [GRAD_W-1:0]    sub_q;

  always_comb begin
    sub_d = $signed({1'b0, a_r}) - $signed({1'b0, rdata_r});
    sub_e = EW'(sub_d);
    if (sub_e > $signed(EW'(GRAD_LIMIT))) begin
      sub_q = GRAD_W'(GRAD_LIMIT);
    end else if (sub_e < -$signed(EW'(GRAD_LIMIT))) begin
      sub_q = -GRAD_W'(GRAD_LIMIT);
    end else begin
      sub_q = sub_e[GRAD_W-1:0];
    end
  end

  // Next state, memory control and register loads.
  logic load_pos, load_a, load_gx, load_out;

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {YW'(cy), XW'(cx)};
    load_pos  = 1'b0;
    load_a    = 1'b0;
    load_gx   = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          if (in_mode == MODE_STORE) begin
            mem_we = in_inside;
          end else begin
            // First read: right neighbour.
            mem_re    = 1'b1;
            mem_addr  = {YW'(cy), XW'(xp)};
            load_pos  = 1'b1;
            state_nxt = S_XM;
          end
        end
      end
      S_XM: begin
        load_a    = 1'b1;
        mem_re    = 1'b1;
        mem_addr  = {YW'(cy), XW'(xm)};
        state_nxt = S_YP;
      end
      S_YP: begin
        load_gx   = 1'b1;
        mem_re    = 1'b1;
        mem_addr  = {YW'(yp), XW'(cx)};
        state_nxt = S_YM;
      end
      S_YM: begin
        load_a    = 1'b1;
        mem_re    = 1'b1;
        mem_addr  = {YW'(ym), XW'(cx)};
        state_nxt = S_GY;
      end
      S_GY: begin
        // The read data holds while no read is issued, so this step can
        // wait for the output register.
        if (slot_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pos) begin
      x_r      <= in_pos_x;
      y_r      <= in_pos_y;
      inside_r <= in_inside;
    end
    if (load_a) begin
      a_r <= rdata_r;
    end
    if (load_gx) begin
      gx_r <= sub_q;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_grad_x_r <= inside_r ? gx_r  : '0;
      out_grad_y_r <= inside_r ? sub_q : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_grad_x = out_grad_x_r;
  assign out_grad_y = out_grad_y_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_mode == MODE_QUERY) |=> (state_r == S_XM))
    else $error("query beat did not start the neighbour reads");

  a_store_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_mode == MODE_STORE) |=> (state_r == S_IDLE))
    else $error("store beat left the sequencer busy");

  a_result_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_GY))
    else $error("result appeared without a finished query");

  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE && !mem_re))
    else $error("height memory written during a query");

endmodule

[tb/height_map_central_gradient_core_tb.sv]
// ----------------------------------------------------------------------------
// height_map_central_gradient_core_tb: self-checking bench for the gradient core
// Store and query beats are driven against a behavioral height map. Every
// result beat is compared with the gradient predicted at query accept time.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the height memory and of the two size
// registers. Stores update that copy when they are accepted, and queries
// compute their gradients from it at the same moment. The core works through
// beats strictly in order, so predicting at accept time matches what the core
// reads. A query is only sent once all four wraparound neighbours hold a
// written sample, because the memory content before the first write is not
// defined. Sizes are only changed while the core is drained.
// ----------------------------------------------------------------------------
module height_map_central_gradient_core_tb;
  import hmcg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  typedef struct {
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
  } gradient_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_stall;
  logic                     in_mode;
  logic [POS_W-1:0]         in_pos_x;
  logic [POS_W-1:0]         in_pos_y;
  logic [IN_HEIGHT_W-1:0]   in_height_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [GRAD_W-1:0] out_grad_x;
  logic signed [GRAD_W-1:0] out_grad_y;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0]    pwdata;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  // Behavioral copy of the height memory, with a flag for every written entry.
  logic [IN_HEIGHT_W-1:0] height_mem [STORE_DEPTH];
  bit                     height_known [STORE_DEPTH];
  logic [CFG_W-1:0]       width_reg;
  logic [CFG_W-1:0]       height_reg;

  // Gradients of accepted queries whose result beat has not arrived yet.
  gradient_t gradient_queue [$];

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int stores_done;
  int stores_dropped;
  int queries_sent;
  int reg_writes;
  int results_checked;
  int error_count;
  int cycle_count;
  int size_step;

  height_map_central_gradient_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_height_value (in_height_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_grad_x      (out_grad_x),
    .out_grad_y      (out_grad_y),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // A hung handshake must not keep the run going forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A size register of zero behaves as one, and anything above the memory
  // size behaves as the memory size.
  function automatic int eff_size(logic [CFG_W-1:0] r, int maxv);
    if (r == '0) return 1;
    if (int'(r) > maxv) return maxv;
    return int'(r);
  endfunction

  function automatic int cur_width();
    return eff_size(width_reg, MAX_WIDTH_DEF);
  endfunction

  function automatic int cur_height();
    return eff_size(height_reg, MAX_HEIGHT_DEF);
  endfunction

  function automatic int wrap_dec(int v, int n);
    return (v == 0) ? n - 1 : v - 1;
  endfunction

  function automatic int wrap_inc(int v, int n);
    return (v + 1 == n) ? 0 : v + 1;
  endfunction

  // With 16-bit samples the clamp never bites, but it keeps the predictor
  // honest for wider height configurations.
  function automatic logic signed [GRAD_W-1:0] height_diff(logic [IN_HEIGHT_W-1:0] plus,
                                                           logic [IN_HEIGHT_W-1:0] minus);
    int d;
    d = int'(plus) - int'(minus);
    if (d > GRAD_LIMIT) d = GRAD_LIMIT;
    if (d < -GRAD_LIMIT) d = -GRAD_LIMIT;
    return d[GRAD_W-1:0];
  endfunction

  // Applies one accepted beat to the behavioral height map. A query inside the
  // image reads its four wraparound neighbours; outside it yields zeros.
  function automatic void record_beat(logic mode, int x, int y, logic [IN_HEIGHT_W-1:0] hv);
    int w;
    int h;
    gradient_t g;
    w = cur_width();
    h = cur_height();
    if (mode == MODE_STORE) begin
      if (x < w && y < h) begin
        height_mem[y*MAX_WIDTH_DEF + x] = hv;
        height_known[y*MAX_WIDTH_DEF + x] = 1'b1;
        stores_done++;
        items_sent++;
      end else begin
        stores_dropped++;
      end
    end else begin
      g.grad_x = '0;
      g.grad_y = '0;
      if (x < w && y < h) begin
        g.grad_x = height_diff(height_mem[y*MAX_WIDTH_DEF + wrap_inc(x, w)],
                               height_mem[y*MAX_WIDTH_DEF + wrap_dec(x, w)]);
        g.grad_y = height_diff(height_mem[wrap_inc(y, h)*MAX_WIDTH_DEF + x],
                               height_mem[wrap_dec(y, h)*MAX_WIDTH_DEF + x]);
      end
      gradient_queue.push_back(g);
      queries_sent++;
      items_sent++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall and the checker share one clocked process. The
  // stall value used for acceptance is the one driven at the previous edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    gradient_t g;
    if (rst_n && out_valid && !out_stall) begin
      if (gradient_queue.size() == 0) begin
        $display("%0t: result beat with no query pending, actual grad_x %0d grad_y %0d",
                 $time, out_grad_x, out_grad_y);
        error_count++;
      end else begin
        g = gradient_queue.pop_front();
        results_checked++;
        if (out_grad_x !== g.grad_x) begin
          $display("%0t: grad_x expected %0d actual %0d", $time, g.grad_x, out_grad_x);
          error_count++;
        end
        if (out_grad_y !== g.grad_y) begin
          $display("%0t: grad_y expected %0d actual %0d", $time, g.grad_y, out_grad_y);
          error_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Sends one beat. Valid is only dropped when a gap is inserted, so back to
  // back beats keep valid high and just swap the payload at the accept edge.
  task automatic send_beat(logic mode, int x, int y, logic [IN_HEIGHT_W-1:0] hv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_pos_x        <= x[POS_W-1:0];
    in_pos_y        <= y[POS_W-1:0];
    in_height_value <= hv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    record_beat(mode, x, y, hv);
  endtask

  // Heights lean toward the extremes so that full-scale differences show up.
  function automatic logic [IN_HEIGHT_W-1:0] pick_height();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return IN_HEIGHT_W'($urandom);
  endfunction

  // Makes sure all four neighbours of (x, y) hold a written sample, refreshes
  // some of them at random, and then sends the query.
  task automatic query_ready(int x, int y, int refresh_pct);
    int w;
    int h;
    int nx [4];
    int ny [4];
    w = cur_width();
    h = cur_height();
    nx = '{wrap_inc(x, w), wrap_dec(x, w), x, x};
    ny = '{y, y, wrap_inc(y, h), wrap_dec(y, h)};
    for (int i = 0; i < 4; i++) begin
      if (!height_known[ny[i]*MAX_WIDTH_DEF + nx[i]] || $urandom_range(99) < refresh_pct)
        send_beat(MODE_STORE, nx[i], ny[i], pick_height());
    end
    send_beat(MODE_QUERY, x, y, IN_HEIGHT_W'($urandom));
  endtask

  // Drops valid and waits until every pending result has been taken. A store
  // is written in the cycle it is accepted, so no store is still in flight then.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gradient_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  // A setup phase and an access phase, followed by an idle step so that a second
  // transfer never raises psel in the step where this one lowers it.
  task automatic apb_cycle(logic wr, logic idx, logic [APB_DATA_W-1:0] data,
                           output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(logic idx, logic [CFG_W-1:0] value);
    logic [APB_DATA_W-1:0] rdata;
    apb_cycle(1'b0, idx, '0, rdata);
    if (rdata !== APB_DATA_W'(value)) begin
      $display("%0t: register %0d read expected %0d actual %0d", $time, idx, value, rdata);
      error_count++;
    end
  endtask

  // Upper data bits are random to show that only the low nine bits count.
  task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
    logic [APB_DATA_W-1:0] data;
    logic [APB_DATA_W-1:0] rdata;
    data = $urandom;
    data[CFG_W-1:0] = value;
    apb_cycle(1'b1, idx, data, rdata);
    if (idx == REG_WIDTH) width_reg = value;
    else height_reg = value;
    reg_writes++;
    check_reg(idx, value);
  endtask

  task automatic set_image(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset sizes are the full memory; a corner query wraps to the far edges.
  task automatic test_reset_size();
    check_reg(REG_WIDTH, WIDTH_RESET);
    check_reg(REG_HEIGHT, HEIGHT_RESET);
    query_ready(255, 255, 0);
  endtask

  // A 3x2 image with full-scale samples: wraparound on every side, the
  // largest positive and negative differences, two rows where above and below
  // are the same texel, and beats that fall outside the image.
  task automatic test_edge_wrap();
    set_image(9'd3, 9'd2);
    send_beat(MODE_STORE, 0, 0, 16'd1234);
    send_beat(MODE_STORE, 1, 0, 16'hFFFF);
    send_beat(MODE_STORE, 2, 0, 16'd0);
    send_beat(MODE_STORE, 0, 1, 16'hFFFF);
    send_beat(MODE_STORE, 1, 1, 16'd5);
    send_beat(MODE_STORE, 2, 1, 16'd0);
    send_beat(MODE_QUERY, 0, 0, 16'd0);
    send_beat(MODE_QUERY, 1, 0, 16'd0);
    send_beat(MODE_QUERY, 2, 1, 16'd0);
    send_beat(MODE_QUERY, 1, 1, 16'd0);
    send_beat(MODE_QUERY, 3, 0, 16'd0);
    send_beat(MODE_QUERY, 0, 2, 16'd0);
    send_beat(MODE_QUERY, 255, 255, 16'hFFFF);
    send_beat(MODE_STORE, 255, 1, 16'h0BAD);
  endtask

  // A zero width acts as one, so both horizontal neighbours are the texel
  // itself. A store dropped there must not disturb the memory once the image
  // grows again. Oversized registers act as the full memory.
  task automatic test_size_one();
    set_image(9'd0, 9'd1);
    send_beat(MODE_QUERY, 0, 0, 16'd0);
    send_beat(MODE_QUERY, 0, 1, 16'd0);
    send_beat(MODE_STORE, 1, 0, 16'd0);
    set_image(9'd3, 9'd2);
    send_beat(MODE_QUERY, 0, 0, 16'd0);
    set_image(9'd511, 9'd300);
    query_ready(1, 0, 0);
    query_ready(255, 0, 0);
  endtask

  // Walks through a fixed list of sizes, the extremes first, then random ones.
  task automatic next_image_size();
    case (size_step % 8)
      0: set_image(9'd256, 9'd256);
      1: set_image(9'd0, 9'd0);
      2: set_image(9'd1, 9'd37);
      3: set_image(9'd45, 9'd1);
      4: set_image(9'd2, 9'd2);
      5: set_image(9'd511, 9'd300);
      default: set_image(CFG_W'($urandom_range(1, 256)), CFG_W'($urandom_range(1, 256)));
    endcase
    size_step++;
  endtask

  // Mostly well-formed queries whose neighbours get written first, mixed with
  // stores anywhere (many of them outside the image) and stray queries.
  task automatic test_random(int n_items, int send_pct, int recv_pct);
    int phase_end;
    int r;
    int x;
    int y;
    int w;
    int h;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int p = 0; p < 5; p++) begin
      next_image_size();
      phase_end = items_sent + n_items / 5;
      while (items_sent < phase_end) begin
        w = cur_width();
        h = cur_height();
        r = $urandom_range(99);
        if (r < 65) begin
          query_ready($urandom_range(w - 1), $urandom_range(h - 1), 20);
        end else if (r < 80) begin
          send_beat(MODE_STORE, $urandom_range(255), $urandom_range(255), pick_height());
        end else if (r < 90) begin
          x = $urandom_range(255);
          y = $urandom_range(255);
          if (x < w && y < h) query_ready(x, y, 0);
          else send_beat(MODE_QUERY, x, y, IN_HEIGHT_W'($urandom));
        end else begin
          send_beat(MODE_STORE, $urandom_range(w - 1), $urandom_range(h - 1), pick_height());
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    in_valid        = 1'b0;
    in_mode         = MODE_STORE;
    in_pos_x        = '0;
    in_pos_y        = '0;
    in_height_value = '0;
    out_stall       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    rst_n           = 1'b0;
    width_reg       = WIDTH_RESET;
    height_reg      = HEIGHT_RESET;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    items_sent      = 0;
    stores_done     = 0;
    stores_dropped  = 0;
    queries_sent    = 0;
    reg_writes      = 0;
    results_checked = 0;
    error_count     = 0;
    cycle_count     = 0;
    size_step       = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part runs with light idling on both sides.
    send_idle_pct = 20;
    recv_idle_pct = 30;
    test_reset_size();
    test_edge_wrap();
    test_size_one();

    // Random part: slow receiver then slow sender, then full rate.
    test_random(480, 35, 73);
    test_random(480, 73, 35);
    test_random(480, 0, 0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (gradient_queue.size() != 0) begin
      $display("%0t: %0d query results never arrived", $time, gradient_queue.size());
      error_count++;
    end

    $display("Covered %0d stores (%0d dropped outside the image), %0d queries, %0d size writes",
             stores_done, stores_dropped, queries_sent, reg_writes);
    $display("Checked %0d gradient beats, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/hmcg_pkg.sv
rtl/height_map_central_gradient_core.sv
tb/height_map_central_gradient_core_tb.sv
